// ===== rtl/rgsd_pkg.sv =====
// ----------------------------------------------------------------------------
// rgsd_pkg - shared types and helpers for the RLE gray scanline decoder
// Position widths, beat structs and the gray to RGB565 colour map.
// ----------------------------------------------------------------------------
`default_nettype none

package rgsd_pkg;

  // Frame positions: width and height fields are 10 bits, so any window end
  // stays below 2^20; one spare bit keeps sums of position and run clear.
  localparam int POS_W = 21;
  localparam int PIX_W = 19;   // stored frame pixel position
  localparam int OFF_W = 13;   // stored buffer offset

  localparam logic [7:0] GRAY_SCALE = 8'd85;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_FIRST_ROW    = 2'd2;
  localparam logic [1:0] REG_ROW_COUNT    = 2'd3;

  typedef logic [POS_W-1:0] pos_t;

  // Window bounds derived from the configuration registers.
  typedef struct packed {
    pos_t total;
    pos_t start_pos;
    pos_t end_pos;
  } cfg_t;

  typedef struct packed {
    logic       first_pair;
    logic [7:0] run_count;
    logic [7:0] run_value;
  } item_t;

  typedef struct packed {
    logic [15:0] pixel_color;
    logic [7:0]  run_length;
    logic [11:0] buffer_offset;
    logic        batch_done;
    logic        terminator_seen;
  } result_t;

  // Gray level 0..3 scaled to 0..255 and packed 5:6:5.
  function automatic logic [15:0] gray_to_565(input logic [1:0] g);
    logic [7:0] gray;
    gray = 8'({6'b0, g} * GRAY_SCALE);
    return {gray[7:3], gray[7:2], gray[7:3]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rgsd_cfg.sv =====
// ----------------------------------------------------------------------------
// rgsd_cfg - configuration registers and window bounds
// APB register file; frame total and window bounds registered in two steps.
// ----------------------------------------------------------------------------
`default_nettype none

module rgsd_cfg
  import rgsd_pkg::*;
#(
  parameter int MAX_WIDTH      = 512,
  parameter int MAX_HEIGHT     = 512,
  parameter int MAX_BATCH_ROWS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             bounds,
  output logic             busy
);

  // Saturation limits, held to what the register fields can carry.
  localparam int W_LIM  = (MAX_WIDTH > 1023) ? 1023 : MAX_WIDTH;
  localparam int H_LIM  = (MAX_HEIGHT > 1023) ? 1023 : MAX_HEIGHT;
  localparam int RC_LIM = (MAX_BATCH_ROWS > 15) ? 15 : MAX_BATCH_ROWS;

  logic [9:0] frame_width;
  logic [9:0] frame_height;
  logic [8:0] first_row;
  logic [3:0] row_count;
  logic [1:0] settle;

  logic        wr;
  logic [1:0]  wr_idx;
  logic [9:0]  w_eff;
  logic [9:0]  h_eff;
  logic [3:0]  rc_eff;
  logic [9:0]  row_end;
  logic [19:0] prod_total;
  logic [18:0] prod_start;
  logic [19:0] prod_end;

  pos_t total_s1;
  pos_t start_s1;
  pos_t end_s1;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign wr_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 10'd240;
      frame_height <= 10'd240;
      first_row    <= 9'd0;
      row_count    <= 4'd8;
      settle       <= 2'd2;
    end else begin
      if (wr) begin
        unique case (wr_idx)
          REG_FRAME_WIDTH:  frame_width  <= pwdata[9:0];
          REG_FRAME_HEIGHT: frame_height <= pwdata[9:0];
          REG_FIRST_ROW:    first_row    <= pwdata[8:0];
          REG_ROW_COUNT:    row_count    <= pwdata[3:0];
          default: ;
        endcase
        settle <= 2'd2;
      end else if (settle != 2'd0) begin
        settle <= settle - 2'd1;
      end
    end
  end

  always_comb begin
    unique case (wr_idx)
      REG_FRAME_WIDTH:  prdata = {22'd0, frame_width};
      REG_FRAME_HEIGHT: prdata = {22'd0, frame_height};
      REG_FIRST_ROW:    prdata = {23'd0, first_row};
      REG_ROW_COUNT:    prdata = {28'd0, row_count};
      default:          prdata = 32'd0;
    endcase
  end

  assign w_eff  = (frame_width > 10'(W_LIM)) ? 10'(W_LIM) : frame_width;
  assign h_eff  = (frame_height > 10'(H_LIM)) ? 10'(H_LIM) : frame_height;
  assign rc_eff = (row_count > 4'(RC_LIM)) ? 4'(RC_LIM) : row_count;
  assign row_end = {1'b0, first_row} + {6'd0, rc_eff};

  always_comb begin
    prod_total = w_eff * h_eff;
    prod_start = first_row * w_eff;
    prod_end   = row_end * w_eff;
  end

  // Step one: products. Step two: window end clipped to the frame.
  always_ff @(posedge clk) begin
    total_s1 <= {1'b0, prod_total};
    start_s1 <= {2'b0, prod_start};
    end_s1   <= {1'b0, prod_end};
    bounds.total     <= total_s1;
    bounds.start_pos <= start_s1;
    bounds.end_pos   <= (end_s1 > total_s1) ? total_s1 : end_s1;
  end

  assign busy = (settle != 2'd0);

endmodule

`default_nettype wire

// ===== rtl/rgsd_core.sv =====
// ----------------------------------------------------------------------------
// rgsd_core - run clipping and decoder position state
// Clips one pair to the window and advances pixel and buffer positions.
// ----------------------------------------------------------------------------
`default_nettype none

module rgsd_core
  import rgsd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic fire,
  input  item_t     item,
  input  cfg_t      bounds,
  output logic      emit,
  output result_t   res
);

  logic [PIX_W-1:0] pixel_pos, pixel_pos_next;
  logic [OFF_W-1:0] out_pos, out_pos_next;
  logic             done_flag, done_flag_next;

  logic [PIX_W-1:0] px;
  logic [OFF_W-1:0] op;
  logic             was_done;
  pos_t             px_w;
  pos_t             room;
  pos_t             sum;
  pos_t             lo;
  logic [7:0]       take;
  logic [7:0]       len;
  logic             reach_end;

  // first_pair clears the position before the pair is decoded
  assign px       = item.first_pair ? '0 : pixel_pos;
  assign op       = item.first_pair ? '0 : out_pos;
  assign was_done = item.first_pair ? 1'b0 : done_flag;

  assign px_w = {2'b0, px};
  assign room = bounds.end_pos - px_w;

  always_comb begin
    if (px_w < bounds.end_pos) begin
      take = ({13'd0, item.run_count} > room) ? room[7:0] : item.run_count;
    end else begin
      take = 8'd0;
    end
  end

  assign sum       = px_w + {13'd0, take};
  assign lo        = (px_w > bounds.start_pos) ? px_w : bounds.start_pos;
  assign len       = (sum > lo) ? 8'(sum - lo) : 8'd0;
  assign reach_end = (sum >= bounds.end_pos);

  always_comb begin
    pixel_pos_next = px;
    out_pos_next   = op;
    done_flag_next = was_done;
    emit           = 1'b0;
    res.pixel_color     = 16'd0;
    res.run_length      = 8'd0;
    res.buffer_offset   = op[11:0];
    res.batch_done      = 1'b1;
    res.terminator_seen = 1'b0;
    priority if (was_done) begin
      // batch already ended: pair ignored
    end else if (px_w >= bounds.total) begin
      done_flag_next = 1'b1;
      emit           = 1'b1;
    end else if (item.run_count == 8'd0) begin
      done_flag_next      = 1'b1;
      emit                = 1'b1;
      res.terminator_seen = 1'b1;
    end else begin
      pixel_pos_next  = sum[PIX_W-1:0];
      out_pos_next    = op + {5'd0, len};
      done_flag_next  = reach_end;
      emit            = (len != 8'd0) || reach_end;
      res.pixel_color = gray_to_565(item.run_value[1:0]);
      res.run_length  = len;
      res.batch_done  = reach_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_pos <= '0;
      out_pos   <= '0;
      done_flag <= 1'b0;
    end else if (fire) begin
      pixel_pos <= pixel_pos_next;
      out_pos   <= out_pos_next;
      done_flag <= done_flag_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rle_gray2_scanline_decoder.sv =====
// ----------------------------------------------------------------------------
// rle_gray2_scanline_decoder - run-length decoder for 2-bit gray scanlines
// Clips (count, value) runs to a batch of rows and emits RGB565 runs.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one beat per run-length pair (first_pair, run_count,
//   run_value), taken when in_valid is high and in_stall low.
//   Output channel: one beat per clipped run (pixel_color, run_length,
//   buffer_offset, batch_done, terminator_seen), taken when out_valid is
//   high and out_stall low. A pair wholly outside the window that does not
//   close it, or one seen after the batch ended, gives no beat.
//   Path: each pair passes the input register, then the clip logic into
//   the output register.
//   Throughput: one pair per cycle unless stalled, set by the single clip pass
//   that also updates the pixel and buffer positions.
//   Stall: with out_stall high the finished beat holds in the output
//   register while one more pair waits in the input register; then
//   in_stall rises in the same cycle.
//   Reset (rst, synchronous) restores the register defaults (240 x 240,
//   first row 0, 8 rows) and clears the positions. After reset or after
//   any register write, in_stall stays high while the window bounds are
//   recomputed.
//   Registers via APB at byte addresses 0, 4, 8, 12: frame_width,
//   frame_height, first_row, row_count. pready is tied high.
// ----------------------------------------------------------------------------
`default_nettype none

module rle_gray2_scanline_decoder
  import rgsd_pkg::*;
#(
  parameter int MAX_WIDTH      = 512,
  parameter int MAX_HEIGHT     = 512,
  parameter int MAX_BATCH_ROWS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // input beats
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        first_pair,
  input  wire logic [7:0]  run_count,
  input  wire logic [7:0]  run_value,
  // output beats
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [15:0] pixel_color,
  output logic      [7:0]  run_length,
  output logic      [11:0] buffer_offset,
  output logic             batch_done,
  output logic             terminator_seen
);

  cfg_t    bounds;
  logic    cfg_busy;

  item_t   item;
  logic    item_valid;
  logic    advance;
  logic    in_take;
  logic    emit;
  result_t res;
  result_t res_q;

  rgsd_cfg #(
    .MAX_WIDTH      (MAX_WIDTH),
    .MAX_HEIGHT     (MAX_HEIGHT),
    .MAX_BATCH_ROWS (MAX_BATCH_ROWS)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .bounds  (bounds),
    .busy    (cfg_busy)
  );

  // Held pair moves on when the output register is free or being drained.
  assign advance  = item_valid && (!out_valid || !out_stall);
  assign in_stall = cfg_busy || (item_valid && !advance);
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_take) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item.first_pair <= first_pair;
      item.run_count  <= run_count;
      item.run_value  <= run_value;
    end
  end

  rgsd_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (item),
    .bounds (bounds),
    .emit   (emit),
    .res    (res)
  );

  // Output register: loaded on advance, cleared once its beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      res_q <= res;
    end
  end

  assign pixel_color     = res_q.pixel_color;
  assign run_length      = res_q.run_length;
  assign buffer_offset   = res_q.buffer_offset;
  assign batch_done      = res_q.batch_done;
  assign terminator_seen = res_q.terminator_seen;

endmodule

`default_nettype wire

// ===== sim/rle_gray2_scanline_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// rle_gray2_scanline_decoder_tb - self-checking bench for the RLE scanline decoder
// Drives run-length pairs through the valid/stall input channel and programs
// the window over APB between phases. A behavioural model of the clipping
// predicts every output beat, and a monitor compares each beat field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module rle_gray2_scanline_decoder_tb;
  import rgsd_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int RANDOM_PAIRS   = 1870;
  localparam int SETTLE_CYCLES  = 6;      // input and output registers plus margin
  localparam int FRAME_PAIR_CAP = 40;     // pairs per frame before a restart
  localparam int END_WAIT_LIMIT = 5000;
  localparam int LIMIT_CYCLES   = 400000;

  // saturation points of the registers, as built into the block
  localparam int MAX_W    = 512;
  localparam int MAX_H    = 512;
  localparam int MAX_ROWS = 8;

  typedef enum logic {
    ROW_PAIR,
    ROW_CFG
  } row_kind_t;

  // one line of the directed table: a register write or a pair, the latter
  // optionally with its expected beat typed in
  typedef struct packed {
    row_kind_t  kind;
    logic [1:0] reg_idx;
    logic [9:0] reg_val;
    logic       first;
    logic [7:0] count;
    logic [7:0] value;
    logic       typed;
    result_t    want;
  } plan_row_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic        first_pair;
  logic [7:0]  run_count;
  logic [7:0]  run_value;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] pixel_color;
  logic [7:0]  run_length;
  logic [11:0] buffer_offset;
  logic        batch_done;
  logic        terminator_seen;

  rle_gray2_scanline_decoder DUT (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .first_pair      (first_pair),
    .run_count       (run_count),
    .run_value       (run_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .pixel_color     (pixel_color),
    .run_length      (run_length),
    .buffer_offset   (buffer_offset),
    .batch_done      (batch_done),
    .terminator_seen (terminator_seen)
  );

  // --------------------------------------------------------------------------
  // Model state: our own copy of the registers and the decode positions
  // --------------------------------------------------------------------------
  logic [9:0]  cfg_width;
  logic [9:0]  cfg_height;
  logic [8:0]  cfg_first_row;
  logic [3:0]  cfg_rows;
  logic [18:0] next_pixel;     // frame pixel index of the next run
  logic [12:0] next_offset;    // buffer index of the next emitted pixel
  bit          batch_ended;    // window end or terminator already seen

  result_t expected_runs [$];  // clipped runs awaiting their output beat

  int mismatches     = 0;
  int pairs_sent     = 0;
  int pairs_decoded  = 0;      // pairs not swallowed by an ended batch
  int beats_checked  = 0;
  int done_beats     = 0;
  int term_beats     = 0;
  int phases         = 0;

  // sender burst shaping
  int burst_left     = 0;
  bit sender_idles   = 1'b1;

  // receiver stall pattern
  int stall_left     = 0;
  int flow_left      = 0;

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Failure reporting: one line per mismatch, count kept
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // --------------------------------------------------------------------------
  // Clip predictor. Advances the model state for one accepted pair and says
  // whether a beat follows and what it carries.
  // --------------------------------------------------------------------------
  task automatic decode_pair(input logic f, input logic [7:0] c, input logic [7:0] v,
                             output bit emits, output result_t res);
    pos_t        w;
    pos_t        h;
    pos_t        rows;
    pos_t        total;
    pos_t        win_lo;
    pos_t        win_hi;
    pos_t        px;
    pos_t        take;
    pos_t        lo;
    pos_t        span;
    logic [7:0]  gray;
    logic [15:0] color;
    bit          ends;
    emits = 1'b0;
    res   = '0;
    // first pair of a frame rewinds everything before it is decoded
    if (f) begin
      next_pixel  = '0;
      next_offset = '0;
      batch_ended = 1'b0;
    end
    if (batch_ended) return;

    // oversized registers saturate
    w    = pos_t'((cfg_width  > MAX_W)    ? MAX_W    : cfg_width);
    h    = pos_t'((cfg_height > MAX_H)    ? MAX_H    : cfg_height);
    rows = pos_t'((cfg_rows   > MAX_ROWS) ? MAX_ROWS : cfg_rows);
    total  = w * h;
    win_lo = pos_t'(cfg_first_row) * w;
    win_hi = (pos_t'(cfg_first_row) + rows) * w;
    if (win_hi > total) win_hi = total;   // window limited to the frame

    px = pos_t'(next_pixel);
    res.buffer_offset = next_offset[11:0];

    // frame already used up: done beat, nothing decoded
    if (px >= total) begin
      batch_ended    = 1'b1;
      emits          = 1'b1;
      res.batch_done = 1'b1;
      return;
    end
    // zero count terminates the frame
    if (c == 8'd0) begin
      batch_ended         = 1'b1;
      emits               = 1'b1;
      res.batch_done      = 1'b1;
      res.terminator_seen = 1'b1;
      return;
    end

    gray  = 8'(v[1:0] * 8'd85);
    color = (16'(gray >> 3) << 11) | (16'(gray >> 2) << 5) | 16'(gray >> 3);

    // pixels of the run up to the window end, then the part past its start
    if (px < win_hi)
      take = (pos_t'(c) < win_hi - px) ? pos_t'(c) : win_hi - px;
    else
      take = '0;
    lo   = (px > win_lo) ? px : win_lo;
    span = (px + take > lo) ? px + take - lo : '0;

    px          = px + take;
    next_pixel  = px[18:0];
    next_offset = next_offset + span[12:0];   // wraps in 13 bits
    ends        = (px >= win_hi);
    if (ends) batch_ended = 1'b1;

    // run wholly outside the window and not closing it: no beat
    if (span == '0 && !ends) return;
    emits           = 1'b1;
    res.pixel_color = color;
    res.run_length  = span[7:0];
    res.batch_done  = ends;
  endtask

  // --------------------------------------------------------------------------
  // Input channel: one beat per call, with burst gaps in front of it
  // --------------------------------------------------------------------------
  task automatic send_pair(input logic f, input logic [7:0] c, input logic [7:0] v,
                           input logic typed, input result_t typed_want);
    bit      emits;
    bit      swallowed;
    result_t predicted;
    int      gap;
    swallowed = batch_ended && !f;
    @(negedge clk);
    if (sender_idles && burst_left == 0) begin
      gap        = $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      in_valid   = 1'b0;
      repeat (gap) @(negedge clk);
    end
    if (burst_left > 0) burst_left--;
    in_valid   = 1'b1;
    first_pair = f;
    run_count  = c;
    run_value  = v;
    // hold the beat until the block takes it
    do @(posedge clk); while (in_stall);
    decode_pair(f, c, v, emits, predicted);
    if (typed)
      expected_runs.push_back(typed_want);
    else if (emits)
      expected_runs.push_back(predicted);
    pairs_sent++;
    if (!swallowed) pairs_decoded++;
  endtask

  // Quiet the input side and let the pipe empty. Pairs that give no beat may
  // still be inside, hence the extra cycles after the last expected beat.
  task automatic settle_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_runs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup then access; only called with the block idle
  task automatic write_reg(input logic [1:0] r, input logic [9:0] v);
    settle_idle();
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {r, 2'b00};
    pwdata  = ($urandom() & ~32'h3FF) | 32'(v);   // junk above the field
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (r)
      REG_FRAME_WIDTH:  cfg_width     = v;
      REG_FRAME_HEIGHT: cfg_height    = v;
      REG_FIRST_ROW:    cfg_first_row = v[8:0];
      REG_ROW_COUNT:    cfg_rows      = v[3:0];
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Directed table builders
  // --------------------------------------------------------------------------
  function automatic plan_row_t cfg_row(input logic [1:0] r, input logic [9:0] v);
    plan_row_t row;
    row         = '0;
    row.kind    = ROW_CFG;
    row.reg_idx = r;
    row.reg_val = v;
    return row;
  endfunction

  function automatic plan_row_t pair_row(input logic f, input logic [7:0] c,
                                         input logic [7:0] v);
    plan_row_t row;
    row       = '0;
    row.kind  = ROW_PAIR;
    row.first = f;
    row.count = c;
    row.value = v;
    return row;
  endfunction

  function automatic plan_row_t typed_row(input logic f, input logic [7:0] c,
                                          input logic [7:0] v, input logic [15:0] col,
                                          input logic [7:0] len, input logic [11:0] off,
                                          input logic d, input logic t);
    plan_row_t row;
    row                      = pair_row(f, c, v);
    row.typed                = 1'b1;
    row.want.pixel_color     = col;
    row.want.run_length      = len;
    row.want.buffer_offset   = off;
    row.want.batch_done      = d;
    row.want.terminator_seen = t;
    return row;
  endfunction

  // run length mix: some terminators, some short and full-length runs
  function automatic logic [7:0] pick_run_count();
    int sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) return 8'd0;
    if (sel <= 2) return 8'($urandom_range(1, 3));
    if (sel == 3) return 8'd255;
    return 8'($urandom_range(1, 255));
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: stall pattern of its own, with occasional long clear stretches
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else if (flow_left > 0) begin
      out_stall = 1'b0;
      flow_left--;
    end else begin
      flow_left  = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 30);
      stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      out_stall  = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every taken output beat against the oldest expected run
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_beats
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      beats_checked++;
      if (batch_done) done_beats++;
      if (terminator_seen) term_beats++;
      if (expected_runs.size() == 0) begin
        report_mismatch("output beat with nothing expected", 32'(buffer_offset), 0);
      end else begin
        want = expected_runs.pop_front();
        if (pixel_color !== want.pixel_color)
          report_mismatch("pixel_color", 32'(pixel_color), 32'(want.pixel_color));
        if (run_length !== want.run_length)
          report_mismatch("run_length", 32'(run_length), 32'(want.run_length));
        if (buffer_offset !== want.buffer_offset)
          report_mismatch("buffer_offset", 32'(buffer_offset), 32'(want.buffer_offset));
        if (batch_done !== want.batch_done)
          report_mismatch("batch_done", 32'(batch_done), 32'(want.batch_done));
        if (terminator_seen !== want.terminator_seen)
          report_mismatch("terminator_seen", 32'(terminator_seen),
                          32'(want.terminator_seen));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    plan_row_t  plan [$];
    logic [9:0] w;
    logic [9:0] h;
    logic [9:0] fr;
    logic [9:0] rc;
    bit         extreme;
    int         frames;
    int         k;
    int         directed_sent;
    int         waited;
    result_t    left;
    result_t    none;

    none = '0;
    rst        = 1'b1;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid   = 1'b0;
    first_pair = 1'b0;
    run_count  = '0;
    run_value  = '0;

    // register defaults after reset
    cfg_width     = 10'd240;
    cfg_height    = 10'd240;
    cfg_first_row = 9'd0;
    cfg_rows      = 4'd8;
    next_pixel    = '0;
    next_offset   = '0;
    batch_ended   = 1'b0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part. Reset window is rows 0..7 of a 240 wide frame: pixels
    // 0..1919. Colours: g1 0x52AA, g2 0xAD55, g3 0xFFFF.
    plan = '{
      // full-length runs of every gray level from reset, offsets accumulate
      typed_row(1'b1, 8'd255, 8'h00, 16'h0000, 8'd255, 12'd0,    1'b0, 1'b0),
      typed_row(1'b0, 8'd255, 8'h01, 16'h52AA, 8'd255, 12'd255,  1'b0, 1'b0),
      typed_row(1'b0, 8'd255, 8'h02, 16'hAD55, 8'd255, 12'd510,  1'b0, 1'b0),
      typed_row(1'b0, 8'd255, 8'hFF, 16'hFFFF, 8'd255, 12'd765,  1'b0, 1'b0),
      typed_row(1'b0, 8'd1,   8'hFC, 16'h0000, 8'd1,   12'd1020, 1'b0, 1'b0),
      pair_row (1'b0, 8'd255, 8'h5A),
      pair_row (1'b0, 8'd255, 8'hA5),
      pair_row (1'b0, 8'd255, 8'h3C),
      // run clipped at the window end, then a pair swallowed after done
      pair_row (1'b0, 8'd255, 8'hC3),
      pair_row (1'b0, 8'd7,   8'h00),
      // terminator as the first pair of a frame, then another swallowed pair
      typed_row(1'b1, 8'd0,   8'hAA, 16'h0000, 8'd0,   12'd0,    1'b1, 1'b1),
      pair_row (1'b0, 8'd9,   8'h01),
      typed_row(1'b1, 8'd128, 8'h55, 16'h52AA, 8'd128, 12'd0,    1'b0, 1'b0),
      typed_row(1'b0, 8'd0,   8'hAA, 16'h0000, 8'd0,   12'd128,  1'b1, 1'b1),
      // zero width: frame exhausted before anything is decoded
      cfg_row(REG_FRAME_WIDTH, 10'd0),
      typed_row(1'b1, 8'd10,  8'h03, 16'h0000, 8'd0,   12'd0,    1'b1, 1'b0),
      // window starting beyond the frame
      cfg_row(REG_FRAME_WIDTH, 10'd16),
      cfg_row(REG_FRAME_HEIGHT, 10'd4),
      cfg_row(REG_FIRST_ROW, 10'd10),
      typed_row(1'b1, 8'd100, 8'h03, 16'hFFFF, 8'd0,   12'd0,    1'b1, 1'b0),
      // one-row window: a run before it, one straddling its start, one its end
      cfg_row(REG_FRAME_HEIGHT, 10'd16),
      cfg_row(REG_FIRST_ROW, 10'd2),
      cfg_row(REG_ROW_COUNT, 10'd1),
      pair_row (1'b1, 8'd20,  8'h01),
      pair_row (1'b0, 8'd20,  8'hFE),
      pair_row (1'b0, 8'd255, 8'h03),
      // empty window
      cfg_row(REG_ROW_COUNT, 10'd0),
      pair_row (1'b1, 8'd40,  8'h01),
      // oversized registers saturate: 512 wide, one row, eight-row window
      cfg_row(REG_FRAME_WIDTH, 10'd1023),
      cfg_row(REG_FRAME_HEIGHT, 10'd1),
      cfg_row(REG_FIRST_ROW, 10'd0),
      cfg_row(REG_ROW_COUNT, 10'd15),
      pair_row (1'b1, 8'd255, 8'h02),
      pair_row (1'b0, 8'd255, 8'h81),
      pair_row (1'b0, 8'd255, 8'h7F)
    };

    sender_idles = 1'b1;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG)
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      else
        send_pair(plan[i].first, plan[i].count, plan[i].value, plan[i].typed,
                  plan[i].want);
    end
    directed_sent = pairs_sent;

    // Random part: phases of one window setting each, mostly well-formed
    // frames, some resumed without a first pair, with noise mixed in.
    while (pairs_sent < directed_sent + RANDOM_PAIRS) begin
      phases++;
      extreme = ($urandom_range(0, 3) == 0);
      if (extreme) begin
        case ($urandom_range(0, 3))
          0: w = 10'd0;
          1: w = 10'd1;
          2: w = 10'd512;
          default: w = 10'd1023;
        endcase
        case ($urandom_range(0, 3))
          0: h = 10'd0;
          1: h = 10'd1;
          2: h = 10'd512;
          default: h = 10'd1023;
        endcase
        fr = ($urandom_range(0, 1) == 0) ? 10'd0 : 10'd511;
        case ($urandom_range(0, 2))
          0: rc = 10'd0;
          1: rc = 10'd8;
          default: rc = 10'd15;
        endcase
      end else begin
        // small frames keep the window within reach of a few dozen pairs
        w  = 10'($urandom_range(1, 40));
        h  = 10'($urandom_range(1, 40));
        fr = 10'($urandom_range(0, h));
        rc = 10'($urandom_range(0, 15));
      end
      write_reg(REG_FRAME_WIDTH, w);
      write_reg(REG_FRAME_HEIGHT, h);
      write_reg(REG_FIRST_ROW, fr);
      write_reg(REG_ROW_COUNT, rc);

      sender_idles = ($urandom_range(0, 4) != 0);
      frames = $urandom_range(1, 4);
      for (int fi = 0; fi < frames; fi++) begin
        // now and then carry on from where the last setting left off
        if ($urandom_range(0, 5) != 0)
          send_pair(1'b1, pick_run_count(), 8'($urandom_range(0, 255)), 1'b0, none);
        k = 0;
        while (!batch_ended && k < FRAME_PAIR_CAP) begin
          send_pair(($urandom_range(0, 30) == 0), pick_run_count(),
                    8'($urandom_range(0, 255)), 1'b0, none);
          k++;
        end
        // stray pairs after the batch ended
        repeat ($urandom_range(0, 2))
          send_pair(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    1'b0, none);
      end
    end

    // Wind down: every expected beat in, then a few cycles for strays
    @(negedge clk);
    in_valid = 1'b0;
    waited = 0;
    while (expected_runs.size() != 0 && waited < END_WAIT_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (expected_runs.size() != 0) begin
      left = expected_runs.pop_front();
      report_mismatch("expected beat never arrived", 32'(left.buffer_offset), 0);
    end

    $display("covered %0d pairs (%0d decoded) over %0d window settings",
             pairs_sent, pairs_decoded, phases);
    $display("checked %0d beats: %0d closing a batch, %0d on a terminator",
             beats_checked, done_beats, term_beats);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("watchdog expired with %0d beats outstanding", expected_runs.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/rgsd_pkg.sv
rtl/rgsd_cfg.sv
rtl/rgsd_core.sv
rtl/rle_gray2_scanline_decoder.sv
sim/rle_gray2_scanline_decoder_tb.sv
